// ===== src/mieu_pkg.sv =====
// shared types and constants for the modular inverse unit
package mieu_pkg;

  // fixed port width of the operand and result fields, and default working width
  localparam int unsigned OPER_W  = 32;
  localparam int unsigned DEF_WIDTH = 32;

  // status codes on the result channel
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_FIN_ERR,
    ST_FIN_ONE,
    ST_FIN_COEF
  } state_t;

  // which result the output register takes
  typedef enum logic [1:0] {
    RES_ERR,
    RES_ONE,
    RES_COEF
  } res_kind_t;

  // controller to datapath commands
  typedef struct packed {
    logic      load;
    logic      init_div;
    logic      div_step;
    logic      update;
    logic      out_load;
    res_kind_t out_kind;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic zero_op;
    logic lo_one;
    logic div_last;
    logic rem_zero;
    logic rem_one;
    logic out_free;
  } stat_t;

endpackage

// ===== src/mieu_ctrl.sv =====
// controller state machine sequencing the euclid steps
module mieu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mieu_pkg::stat_t stat,
  output mieu_pkg::cmd_t  cmd
);
  import mieu_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.out_kind = RES_ERR;
    in_stall     = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.zero_op) begin
          state_nxt = ST_FIN_ERR;
        end else if (stat.lo_one) begin
          state_nxt = ST_FIN_ONE;
        end else begin
          cmd.init_div = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        if (stat.rem_one) begin
          state_nxt = ST_FIN_COEF;
        end else if (stat.rem_zero) begin
          state_nxt = ST_FIN_ERR;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_FIN_ERR: begin
        cmd.out_kind = RES_ERR;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_FIN_ONE: begin
        cmd.out_kind = RES_ONE;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_FIN_COEF: begin
        cmd.out_kind = RES_COEF;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/mieu_dp.sv =====
// datapath: operand registers, restoring divider, coefficient and output register
module mieu_dp #(
  parameter int unsigned WIDTH = mieu_pkg::DEF_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [mieu_pkg::OPER_W-1:0]  in_operand_a,
  input  logic [mieu_pkg::OPER_W-1:0]  in_operand_b,
  input  mieu_pkg::cmd_t               cmd,
  output mieu_pkg::stat_t              stat,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mieu_pkg::OPER_W-1:0]  out_inverse_value,
  output logic                         out_status
);
  import mieu_pkg::*;

  localparam int unsigned CNT_W = $clog2(WIDTH);

  logic [WIDTH-1:0] a_w, b_w;
  logic [WIDTH-1:0] hi_r, lo_r, modulus_r;
  logic [WIDTH-1:0] div_r, rem_r, acc_r;
  logic [WIDTH-1:0] mag_prev_r, mag_cur_r;
  logic             neg_cur_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  logic [OPER_W-1:0] out_inv_r;
  logic             out_status_r;

  logic [WIDTH:0]   shifted, diff;
  logic             qbit;
  logic [WIDTH-1:0] rem_nxt, acc_nxt, mag_new, coef_res;

  // operands cut or extended to the working width
  assign a_w = WIDTH'(in_operand_a);
  assign b_w = WIDTH'(in_operand_b);

  // one restoring division bit, with shift-add of quotient times coefficient
  always_comb begin
    shifted = {rem_r, div_r[WIDTH-1]};
    diff    = shifted - {1'b0, lo_r};
    qbit    = ~diff[WIDTH];
    rem_nxt = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    acc_nxt = {acc_r[WIDTH-2:0], 1'b0} + (qbit ? mag_cur_r : '0);
  end

  // next coefficient magnitude and lifted final coefficient
  assign mag_new  = mag_prev_r + acc_r;
  assign coef_res = (neg_cur_r && (mag_cur_r != '0)) ? (modulus_r - mag_cur_r) : mag_cur_r;

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hi_r       <= (a_w > b_w) ? a_w : b_w;
      lo_r       <= (a_w > b_w) ? b_w : a_w;
      modulus_r  <= (a_w > b_w) ? a_w : b_w;
      mag_prev_r <= '0;
      mag_cur_r  <= WIDTH'(1);
      neg_cur_r  <= 1'b0;
    end
    if (cmd.init_div) begin
      div_r <= hi_r;
      rem_r <= '0;
      acc_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      div_r <= {div_r[WIDTH-2:0], 1'b0};
      rem_r <= rem_nxt;
      acc_r <= acc_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.update) begin
      hi_r       <= lo_r;
      lo_r       <= rem_r;
      mag_prev_r <= mag_cur_r;
      mag_cur_r  <= mag_new;
      neg_cur_r  <= ~neg_cur_r;
      // next division takes the old divisor as dividend
      div_r      <= lo_r;
      rem_r      <= '0;
      acc_r      <= '0;
      cnt_r      <= '0;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_kind)
        RES_ONE: begin
          out_inv_r    <= OPER_W'(1);
          out_status_r <= STATUS_OK;
        end
        RES_COEF: begin
          out_inv_r    <= OPER_W'(coef_res);
          out_status_r <= STATUS_OK;
        end
        default: begin
          out_inv_r    <= '0;
          out_status_r <= STATUS_ERR;
        end
      endcase
    end
  end

  // status to the controller
  always_comb begin
    stat.zero_op  = (lo_r == '0);
    stat.lo_one   = (lo_r == WIDTH'(1));
    stat.div_last = (cnt_r == CNT_W'(WIDTH - 1));
    stat.rem_zero = (rem_r == '0);
    stat.rem_one  = (rem_r == WIDTH'(1));
    stat.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid         = out_valid_r;
  assign out_inverse_value = out_inv_r;
  assign out_status        = out_status_r;

endmodule

// ===== src/modular_inverse_ext_euclid_unit.sv =====
// top level of the modular inverse unit (extended euclid)
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall  | in_operand_a, in_operand_b
//   out     | output    | out_valid / out_stall| out_inverse_value, out_status
//
// one item at a time: the accept edge loads the operands, a check state follows, then
// each euclid step runs the restoring divider, giving one quotient bit a cycle,
// and then an update state; the result is loaded once the output register is free.
// a zero operand gives an error at once, a smaller operand of one an inverse of one.
// reset (rst_n low, synchronous) empties the unit and the output register.
// a stalled result holds in the output register while the next item is taken.
module modular_inverse_ext_euclid_unit #(
  parameter int unsigned WIDTH = mieu_pkg::DEF_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mieu_pkg::OPER_W-1:0]  in_operand_a,
  input  logic [mieu_pkg::OPER_W-1:0]  in_operand_b,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mieu_pkg::OPER_W-1:0]  out_inverse_value,
  output logic                         out_status
);
  import mieu_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // controller
  mieu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  mieu_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_operand_a      (in_operand_a),
    .in_operand_b      (in_operand_b),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_inverse_value (out_inverse_value),
    .out_status        (out_status)
  );

  // an accepted item keeps the unit busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("unit not busy after accepting an item");

  // an error result carries a zero inverse
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STATUS_ERR)) |-> (out_inverse_value == '0))
    else $error("error result with nonzero inverse");

  // a new result only comes from a busy unit
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while unit was idle");

  // at most one datapath command is active at a time
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.init_div, cmd.div_step, cmd.update, cmd.out_load}))
    else $error("conflicting datapath commands");

endmodule
